// File: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page frame replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 8;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int FAULT_W    = 16;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [FAULT_W-1:0] FAULT_MAX   = {FAULT_W{1'b1}};
	localparam logic [CNT_W-1:0]   FRAMES_RST  = CNT_W'(MAX_FRAMES);

	// register index, taken from paddr[2]
	localparam logic REG_FRAMES = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT
	} lrupr_state_t;

	typedef struct packed {
		logic load;   // capture the incoming page
		logic apply;  // update the table, rewind the slot counter
		logic step;   // advance to the next slot
	} lrupr_cmd_t;

	typedef struct packed {
		logic last;   // slot counter on the last frame in use
	} lrupr_sts_t;

endpackage

// File: rtl/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: accept a page, update the table, stream one word per frame.
// ----------------------------------------------------------------------------
module lrupr_ctrl import lrupr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output lrupr_cmd_t cmd,
	input  lrupr_sts_t sts
);

	lrupr_state_t state_q;
	lrupr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.apply = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/lrupr_dp.sv
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame table with rank-based recency, fault counter and output word mux.
// ----------------------------------------------------------------------------
module lrupr_dp import lrupr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrupr_cmd_t           cmd,
	output lrupr_sts_t           sts,
	input  logic                 clear,
	input  logic [CNT_W-1:0]     frames,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic [IDX_W-1:0]     slot_index,
	output logic [PAGE_BITS-1:0] slot_page,
	output logic                 page_fault,
	output logic [FAULT_W-1:0]   fault_total,
	output logic                 last_slot
);

	logic [PAGE_BITS-1:0] pages_q [MAX_FRAMES];
	logic [IDX_W-1:0]     rank_q  [MAX_FRAMES];
	logic [PAGE_BITS-1:0] pages_d [MAX_FRAMES];
	logic [IDX_W-1:0]     rank_d  [MAX_FRAMES];
	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 fault_q;
	logic [FAULT_W-1:0]   fcnt_q;

	logic [CNT_W-1:0]      n_act;
	logic [IDX_W-1:0]      n_last;
	logic [MAX_FRAMES-1:0] in_rng;
	logic [MAX_FRAMES-1:0] occ;
	logic [MAX_FRAMES-1:0] match;
	logic [MAX_FRAMES-1:0] empty;
	logic [MAX_FRAMES-1:0] rank0;
	logic [CNT_W-1:0]      used;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      emp_idx;
	logic [IDX_W-1:0]      vic_idx;
	logic                  hit;
	logic                  miss;
	logic [IDX_W-1:0]      hit_rank;
	logic [IDX_W-1:0]      rank_dec [MAX_FRAMES];

	always_comb begin
		if (frames == '0) begin
			n_act = CNT_W'(1);
		end else if (frames > CNT_W'(MAX_FRAMES)) begin
			n_act = CNT_W'(MAX_FRAMES);
		end else begin
			n_act = frames;
		end
		n_last = IDX_W'(n_act - CNT_W'(1));
	end

	always_comb begin
		used    = '0;
		hit_idx = '0;
		emp_idx = '0;
		vic_idx = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			in_rng[i] = CNT_W'(i) < n_act;
			occ[i]    = in_rng[i] && (pages_q[i] != '0);
			match[i]  = in_rng[i] && (pages_q[i] == page_q);
			empty[i]  = in_rng[i] && (pages_q[i] == '0);
			rank0[i]  = occ[i] && (rank_q[i] == '0);
			used      = used + CNT_W'(occ[i]);
		end
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i]) hit_idx = IDX_W'(i);
			if (empty[i]) emp_idx = IDX_W'(i);
			if (rank0[i]) vic_idx = IDX_W'(i);
		end
		hit      = (page_q != '0) && (match != '0);
		miss     = (page_q != '0) && (match == '0);
		hit_rank = rank_q[hit_idx];
	end

	// next table contents
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			pages_d[i]  = pages_q[i];
			rank_d[i]   = rank_q[i];
			rank_dec[i] = (rank_q[i] != '0) ? rank_q[i] - 1'b1 : rank_q[i];
		end
		if (hit) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (occ[i] && (rank_q[i] > hit_rank)) rank_d[i] = rank_q[i] - 1'b1;
			end
			rank_d[hit_idx] = IDX_W'(used - CNT_W'(1));
		end else if (miss && (used < n_act)) begin
			pages_d[emp_idx] = page_q;
			rank_d[emp_idx]  = IDX_W'(used);
		end else if (miss) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_d[i] = rank_dec[i];
			end
			for (int i = 0; i < MAX_FRAMES - 1; i++) begin
				if ((IDX_W'(i) >= vic_idx) && (IDX_W'(i) < n_last)) begin
					pages_d[i] = pages_q[i + 1];
					rank_d[i]  = rank_dec[i + 1];
				end
			end
			pages_d[n_last] = page_q;
			rank_d[n_last]  = n_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				pages_q[i] <= '0;
				rank_q[i]  <= '0;
			end
			fcnt_q  <= '0;
			fault_q <= 1'b0;
			slot_q  <= '0;
		end else begin
			if (clear) begin
				for (int i = 0; i < MAX_FRAMES; i++) begin
					pages_q[i] <= '0;
					rank_q[i]  <= '0;
				end
			end else if (cmd.apply) begin
				for (int i = 0; i < MAX_FRAMES; i++) begin
					pages_q[i] <= pages_d[i];
					rank_q[i]  <= rank_d[i];
				end
			end
			if (cmd.apply) begin
				fault_q <= miss;
				slot_q  <= '0;
				if (miss && (fcnt_q != FAULT_MAX)) fcnt_q <= fcnt_q + 1'b1;
			end else if (cmd.step) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) page_q <= page_number;
	end

	assign sts.last    = (slot_q == n_last);
	assign slot_index  = slot_q;
	assign slot_page   = pages_q[slot_q];
	assign page_fault  = fault_q;
	assign fault_total = fcnt_q;
	assign last_slot   = sts.last;

endmodule

// File: rtl/lru_page_frame_replacement_top.sv
// A page taken in ST_IDLE updates the table in ST_UPDATE; its frame words
// follow in ST_EMIT, one word per frame in use, one per cycle while rsp_stall
// is low. req_stall holds off a new page until the last word has been taken.
// Reset: all frames empty, ranks and fault total zero, frames_in_use = 16.
// A write to frames_in_use empties the table and keeps the fault total.
// ----------------------------------------------------------------------------
// lru_page_frame_replacement_top
// LRU page frame table: APB register, sequencer and table datapath.
// ----------------------------------------------------------------------------
module lru_page_frame_replacement_top import lrupr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [IDX_W-1:0]     slot_index,
	output logic [PAGE_BITS-1:0] slot_page,
	output logic                 page_fault,
	output logic [FAULT_W-1:0]   fault_total,
	output logic                 last_slot
);

	logic [CNT_W-1:0] frames_q;
	logic             cfg_wr;
	lrupr_cmd_t       cmd;
	lrupr_sts_t       sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RST;
		end else if (cfg_wr) begin
			frames_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAMES: prdata = DATA_W'(frames_q);
			default:    prdata = '0;
		endcase
	end

	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lrupr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.clear       (cfg_wr),
		.frames      (frames_q),
		.page_number (page_number),
		.slot_index  (slot_index),
		.slot_page   (slot_page),
		.page_fault  (page_fault),
		.fault_total (fault_total),
		.last_slot   (last_slot)
	);

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU page frame table. Pages go in on a
// valid/stall port and a local LRU table predicts every frame word that
// comes back. The frame count register is set over APB between phases.
// Directed cases come first, then random traffic under several idle and
// stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top import lrupr_pkg::*; ();

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG    = 5000;
	localparam int ITEMS_PHASE = 22;

	localparam logic [ADDR_W-1:0] FRAMES_ADDR = {REG_FRAMES, 2'b00};
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = {~REG_FRAMES, 2'b00};

	typedef struct {
		logic [IDX_W-1:0]     idx;
		logic [PAGE_BITS-1:0] pg;
		logic                 fault;
		logic [FAULT_W-1:0]   total;
		logic                 last;
	} frame_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [PAGE_BITS-1:0] page_number = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [IDX_W-1:0]     slot_index;
	logic [PAGE_BITS-1:0] slot_page;
	logic                 page_fault;
	logic [FAULT_W-1:0]   fault_total;
	logic                 last_slot;

	// predicted table state
	logic [PAGE_BITS-1:0] table_pg [MAX_FRAMES];
	logic [IDX_W-1:0]     table_rank [MAX_FRAMES];
	logic [FAULT_W-1:0]   fault_cnt = '0;
	logic [4:0]           cfg_frames = 5'(MAX_FRAMES);

	frame_word_t pending_frames[$];

	int  errors = 0;
	int  pages_sent = 0;
	int  words_checked = 0;
	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_off_req = 1'b0;

	lru_page_frame_replacement_top dut (.*);

	always #5 clk = ~clk;

	function automatic int active_frames();
		if (cfg_frames == 0)
			return 1;
		if (cfg_frames > MAX_FRAMES)
			return MAX_FRAMES;
		return cfg_frames;
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < MAX_FRAMES; i++) begin
			table_pg[i]   = '0;
			table_rank[i] = '0;
		end
	endfunction

	// apply one reference to the local table and queue the frame report
	task automatic lru_update_and_report(input logic [PAGE_BITS-1:0] pg);
		int n;
		int used;
		int hit;
		int victim;
		logic [IDX_W-1:0] r;
		logic miss;
		logic placed;
		frame_word_t w;
		n = active_frames();
		used = 0;
		hit = n;
		miss = 1'b0;
		placed = 1'b0;
		for (int i = 0; i < n; i++)
			if (table_pg[i] != 0) used++;
		if (pg != 0) begin
			for (int i = 0; i < n; i++)
				if (hit == n && table_pg[i] == pg) hit = i;
			if (hit < n) begin
				r = table_rank[hit];
				for (int i = 0; i < n; i++)
					if (table_pg[i] != 0 && table_rank[i] > r) table_rank[i]--;
				table_rank[hit] = IDX_W'(used - 1);
			end else begin
				miss = 1'b1;
				if (used < n) begin
					for (int i = 0; i < n; i++) begin
						if (!placed && table_pg[i] == 0) begin
							table_pg[i]   = pg;
							table_rank[i] = IDX_W'(used);
							placed = 1'b1;
						end
					end
				end else begin
					victim = 0;
					for (int i = 1; i < n; i++)
						if (table_rank[i] < table_rank[victim]) victim = i;
					for (int i = 0; i < n; i++)
						if (table_rank[i] > 0) table_rank[i]--;
					for (int i = victim; i + 1 < n; i++) begin
						table_pg[i]   = table_pg[i+1];
						table_rank[i] = table_rank[i+1];
					end
					table_pg[n-1]   = pg;
					table_rank[n-1] = IDX_W'(n - 1);
				end
				if (fault_cnt != FAULT_MAX) fault_cnt++;
			end
		end
		for (int i = 0; i < n; i++) begin
			w.idx   = IDX_W'(i);
			w.pg    = table_pg[i];
			w.fault = miss;
			w.total = fault_cnt;
			w.last  = (i == n - 1);
			pending_frames.push_back(w);
		end
	endtask

	task automatic send_page(input logic [PAGE_BITS-1:0] pg);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		page_number <= pg;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pages_sent++;
		lru_update_and_report(pg);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [4:0] val);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == FRAMES_ADDR) begin
			cfg_frames = val;
			clear_table();
		end
	endtask

	function automatic logic [PAGE_BITS-1:0] pick_page();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return '0;
		if (r < 70)
			return PAGE_BITS'($urandom_range(1, 2 * active_frames() + 2));
		return PAGE_BITS'($urandom_range(1, 255));
	endfunction

	// ---- tests ----

	task automatic test_reset_state();
		send_page(8'd0);
		send_page(8'd255);
		send_page(8'd1);
		send_page(8'd255);
		wait_idle();
	endtask

	task automatic test_lru_order();
		write_reg(FRAMES_ADDR, 5'd4);
		send_page(8'd1);
		send_page(8'd2);
		send_page(8'd3);
		send_page(8'd4);
		send_page(8'd2);
		send_page(8'd5);
		send_page(8'd0);
		send_page(8'd3);
		send_page(8'd170);
		send_page(8'd85);
		wait_idle();
	endtask

	task automatic test_frame_count_limits();
		write_reg(FRAMES_ADDR, 5'd0);
		send_page(8'd7);
		send_page(8'd9);
		write_reg(FRAMES_ADDR, 5'd31);
		send_page(8'd7);
		write_reg(FRAMES_ADDR, 5'd17);
		send_page(8'd8);
		// write to an unmapped register must leave the table alone
		write_reg(UNUSED_ADDR, 5'd2);
		send_page(8'd9);
		write_reg(FRAMES_ADDR, 5'd1);
		send_page(8'd9);
		send_page(8'd10);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int idle_mix [4]  = '{0, 56, 0, 36};
		int stall_mix [4] = '{0, 0, 56, 36};
		logic [4:0] frames_mix [4];
		frames_mix = '{5'd16, 5'(1 + $urandom_range(15)), 5'(1 + $urandom_range(7)),
			5'($urandom_range(31))};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(FRAMES_ADDR, frames_mix[ph]);
			idle_pct  = idle_mix[ph];
			stall_pct = stall_mix[ph];
			for (int k = 0; k < ITEMS_PHASE; k++)
				send_page(pick_page());
			wait_idle();
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	task automatic test_output_hold_off();
		write_reg(FRAMES_ADDR, 5'd3);
		hold_off_req = 1'b1;
		for (int k = 0; k < 12; k++)
			send_page(pick_page());
		wait_idle();
	endtask

	// ---- receiver stall ----

	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// ---- frame word checker ----

	always @(posedge clk) begin
		frame_word_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_frames.size() == 0) begin
				$error("unexpected frame word: slot_index %0d slot_page %0d",
					slot_index, slot_page);
				errors++;
			end else begin
				e = pending_frames.pop_front();
				words_checked++;
				if (slot_index !== e.idx) begin
					$error("slot_index: expected %0d, actual %0d", e.idx, slot_index);
					errors++;
				end
				if (slot_page !== e.pg) begin
					$error("slot_page: expected %0d, actual %0d", e.pg, slot_page);
					errors++;
				end
				if (page_fault !== e.fault) begin
					$error("page_fault: expected %0d, actual %0d", e.fault, page_fault);
					errors++;
				end
				if (fault_total !== e.total) begin
					$error("fault_total: expected %0d, actual %0d", e.total, fault_total);
					errors++;
				end
				if (last_slot !== e.last) begin
					$error("last_slot: expected %0d, actual %0d", e.last, last_slot);
					errors++;
				end
			end
		end
	end

	// ---- watchdog ----

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: timeout, %0d frame words outstanding", pending_frames.size());
		$display("tb: failure");
		$finish;
	end

	// ---- main sequence ----

	initial begin
		clear_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_lru_order();
		test_frame_count_limits();
		test_random_traffic();
		test_output_hold_off();
		$display("tb: %0d pages, %0d frame words checked", pages_sent, words_checked);
		$display("tb: frame counts 1..16 plus clamped writes, idle/stall mixes, hold-off");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
